// ----- rtl/knc_pkg.sv -----
// ---------------------------------------------------------------------------
// knc_pkg: shared types and constants for the k-nearest candidate list
// fixed distance width, register codes, state codes and cell control
// ---------------------------------------------------------------------------
`default_nettype none

package knc_pkg;

    localparam int DIST_BITS = 50;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam int WANT_BITS = 5;
    localparam logic [WANT_BITS-1:0] WANT_RESET = 5'd4;

    // configuration register codes
    typedef enum logic [1:0] {
        CFG_TARGET_X = 2'd0,
        CFG_TARGET_Y = 2'd1,
        CFG_TARGET_Z = 2'd2,
        CFG_WANTED   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HINT,
        S_DRAIN
    } t_state;

    // control shared by every cell of the list
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/knc_dist.sv -----
// ---------------------------------------------------------------------------
// knc_dist: squared distance pipeline
// three stages: absolute differences, squares, saturating sum
// ---------------------------------------------------------------------------
`default_nettype none

module knc_dist #(
    parameter int COORD_BITS = 24
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire  [COORD_BITS-1:0]               i_cand_x,
    input  wire  [COORD_BITS-1:0]               i_cand_y,
    input  wire  [COORD_BITS-1:0]               i_cand_z,
    input  wire  [COORD_BITS-1:0]               i_target_x,
    input  wire  [COORD_BITS-1:0]               i_target_y,
    input  wire  [COORD_BITS-1:0]               i_target_z,
    output logic                                o_valid,
    output logic [knc_pkg::DIST_BITS-1:0]       o_dist
);

    localparam int AD_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS  = 2 * AD_BITS;
    localparam int CMP_BITS = (SQ_BITS > knc_pkg::DIST_BITS + 1) ? SQ_BITS
                                                                 : knc_pkg::DIST_BITS + 1;
    localparam int SUM_BITS = knc_pkg::DIST_BITS + 2;

    logic                  r_v1, r_v2, r_v3;
    logic [AD_BITS-1:0]    r_ad_x, r_ad_y, r_ad_z;
    logic [SQ_BITS-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [knc_pkg::DIST_BITS-1:0] r_dist;

    logic [SUM_BITS-1:0]   sum;

    function automatic logic [AD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        logic signed [AD_BITS-1:0] d;
        d = signed'({a[COORD_BITS-1], a}) - signed'({b[COORD_BITS-1], b});
        return d[AD_BITS-1] ? AD_BITS'(-d) : AD_BITS'(d);
    endfunction

    function automatic logic [knc_pkg::DIST_BITS-1:0] sat_sq(input logic [SQ_BITS-1:0] s);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(s);
        return (w > CMP_BITS'(knc_pkg::DIST_MAX)) ? knc_pkg::DIST_MAX
                                                  : knc_pkg::DIST_BITS'(s);
    endfunction

    // squares are saturated before the sum, the sum saturates once more
    assign sum = SUM_BITS'(sat_sq(r_sq_x)) + SUM_BITS'(sat_sq(r_sq_y))
               + SUM_BITS'(sat_sq(r_sq_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad_x <= abs_diff(i_cand_x, i_target_x);
        r_ad_y <= abs_diff(i_cand_y, i_target_y);
        r_ad_z <= abs_diff(i_cand_z, i_target_z);
        r_sq_x <= SQ_BITS'(r_ad_x) * SQ_BITS'(r_ad_x);
        r_sq_y <= SQ_BITS'(r_ad_y) * SQ_BITS'(r_ad_y);
        r_sq_z <= SQ_BITS'(r_ad_z) * SQ_BITS'(r_ad_z);
        r_dist <= (sum > SUM_BITS'(knc_pkg::DIST_MAX)) ? knc_pkg::DIST_MAX
                                                       : sum[knc_pkg::DIST_BITS-1:0];
    end

    assign o_valid = r_v3;
    assign o_dist  = r_dist;

endmodule

`default_nettype wire

// ----- rtl/knc_cell.sv -----
// ---------------------------------------------------------------------------
// knc_cell: one entry of the sorted candidate list
// keeps, takes the new candidate or takes its lower neighbor on insert;
// takes its upper neighbor while the list drains
// ---------------------------------------------------------------------------
`default_nettype none

module knc_cell #(
    parameter int INDEX_BITS = 16
) (
    input  wire                                 i_clk,
    input  knc_pkg::t_cell_ctrl                 i_ctrl,
    input  wire                                 i_valid,
    input  wire                                 i_prev_less,
    input  wire  [knc_pkg::DIST_BITS-1:0]       i_prev_dist,
    input  wire  [INDEX_BITS-1:0]               i_prev_index,
    input  wire  [knc_pkg::DIST_BITS-1:0]       i_next_dist,
    input  wire  [INDEX_BITS-1:0]               i_next_index,
    input  wire  [knc_pkg::DIST_BITS-1:0]       i_new_dist,
    input  wire  [INDEX_BITS-1:0]               i_new_index,
    output logic                                o_less,
    output logic [knc_pkg::DIST_BITS-1:0]       o_dist,
    output logic [INDEX_BITS-1:0]               o_index
);

    logic [knc_pkg::DIST_BITS-1:0] r_dist;
    logic [INDEX_BITS-1:0]         r_index;

    // strict compare so a new entry lands ahead of equal distances
    assign o_less = i_valid && (r_dist < i_new_dist);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && !o_less) begin
            if (i_prev_less) begin
                r_dist  <= i_new_dist;
                r_index <= i_new_index;
            end else begin
                r_dist  <= i_prev_dist;
                r_index <= i_prev_index;
            end
        end else if (i_ctrl.drain) begin
            r_dist  <= i_next_dist;
            r_index <= i_next_index;
        end
    end

    assign o_dist  = r_dist;
    assign o_index = r_index;

endmodule

`default_nettype wire

// ----- rtl/k_nearest_candidate_list_unit.sv -----
// ---------------------------------------------------------------------------
// k_nearest_candidate_list_unit: sorted list of the nearest candidates
// squared distance to a configured target, insertion into a chain of cells
// ---------------------------------------------------------------------------
// Each candidate transfer on the slave side gives one hint transfer on the
// master side, with tlast set on it unless the candidate is a final one; a
// candidate with tlast set also gives the sorted list, nearest first, one
// entry per transfer, with tlast on the final one (or on the hint when the
// list is empty), and the list is cleared. One candidate is handled at a
// time: its hint comes from a three-stage distance pipeline with the
// multipliers, whose first stage captures the differences at the transfer
// edge, and then from the insertion compare across the cell chain, which
// is registered with the hint. The next candidate is taken only once the
// hint and, on a final candidate, every list entry have been taken on the
// master side, so a stall there holds it too. Configuration writes are taken
// at any time but must only be made while no candidate is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module k_nearest_candidate_list_unit #(
    parameter int MAX_WANTED = 16,
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // configuration write port
    input  wire                         i_cfg_we,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [COORD_BITS-1:0]       i_cfg_data,
    // candidate stream
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    // cand_x, cand_y, cand_z, cand_index, zero pad
    input  wire  [((3*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] i_s_tdata,
    // final_candidate
    input  wire                         i_s_tlast,
    // result stream
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    // prune_hint, neighbor_index, neighbor_distance, zero pad
    output logic [((1+INDEX_BITS+knc_pkg::DIST_BITS+7)/8)*8-1:0] o_m_tdata,
    // kind: 0 hint, 1 list entry
    output logic                        o_m_tuser,
    // last_of_run
    output logic                        o_m_tlast
);

    localparam int DB       = knc_pkg::DIST_BITS;
    localparam int M_BITS   = ((1 + INDEX_BITS + DB + 7) / 8) * 8;
    localparam int FW       = $clog2(MAX_WANTED + 1);
    localparam int IW       = (MAX_WANTED > 1) ? $clog2(MAX_WANTED) : 1;
    localparam int WCW      = (FW > knc_pkg::WANT_BITS) ? FW : knc_pkg::WANT_BITS;

    // configuration registers
    logic [COORD_BITS-1:0]          r_target_x, r_target_y, r_target_z;
    logic [knc_pkg::WANT_BITS-1:0]  r_wanted;

    // control
    knc_pkg::t_state                r_state, n_state;
    logic [FW-1:0]                  r_fill, n_fill;
    logic [INDEX_BITS-1:0]          r_cand_index;
    logic                           r_fin;
    logic                           r_hint, n_hint;
    logic                           r_hint_last, n_hint_last;

    // distance pipeline
    logic                           dist_valid;
    logic [DB-1:0]                  cand_dist;

    // cell chain
    logic [DB-1:0]                  w_dist  [MAX_WANTED];
    logic [INDEX_BITS-1:0]          w_index [MAX_WANTED];
    logic [MAX_WANTED-1:0]          w_less;
    knc_pkg::t_cell_ctrl            cell_ctrl;

    logic                           s_xfer, m_xfer;
    logic [FW-1:0]                  want;
    logic [WCW-1:0]                 wanted_ext;
    logic                           want_nz, full, take;
    logic [FW-1:0]                  fill_m1, fill_eff, eff_m1;
    logic                           hint_full, do_insert;

    assign s_xfer = i_s_tvalid && o_s_tready;
    assign m_xfer = o_m_tvalid && i_m_tready;

    // ---- configuration writes --------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_target_y <= '0;
            r_target_z <= '0;
            r_wanted   <= knc_pkg::WANT_RESET;
        end else if (i_cfg_we) begin
            case (knc_pkg::t_cfg_reg'(i_cfg_index))
                knc_pkg::CFG_TARGET_X: r_target_x <= i_cfg_data;
                knc_pkg::CFG_TARGET_Y: r_target_y <= i_cfg_data;
                knc_pkg::CFG_TARGET_Z: r_target_z <= i_cfg_data;
                knc_pkg::CFG_WANTED:   r_wanted   <= i_cfg_data[knc_pkg::WANT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---- distance ----------------------------------------------------------
    knc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_xfer),
        .i_cand_x   (i_s_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_cand_y   (i_s_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_cand_z   (i_s_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_target_x (r_target_x),
        .i_target_y (r_target_y),
        .i_target_z (r_target_z),
        .o_valid    (dist_valid),
        .o_dist     (cand_dist)
    );

    // ---- insertion decision ------------------------------------------------
    // wanted count saturates at the list depth
    assign wanted_ext = WCW'(r_wanted);
    assign want       = (wanted_ext > WCW'(MAX_WANTED)) ? FW'(MAX_WANTED)
                                                        : FW'(wanted_ext);
    assign want_nz    = (want != '0);
    assign full       = (r_fill >= want);
    assign fill_m1    = r_fill - FW'(1);

    // a full list only takes a candidate strictly nearer than its last entry
    assign take       = !full || (cand_dist < w_dist[fill_m1[IW-1:0]]);

    // on a full list the last entry is dropped before the insert
    assign fill_eff   = full ? fill_m1 : r_fill;
    assign eff_m1     = fill_eff - FW'(1);
    assign hint_full  = (fill_eff == '0) || (cand_dist > w_dist[eff_m1[IW-1:0]]);

    assign do_insert  = (r_state == knc_pkg::S_CALC) && dist_valid && want_nz && take;

    assign cell_ctrl.insert = do_insert;
    assign cell_ctrl.drain  = (r_state == knc_pkg::S_DRAIN) && i_m_tready;

    // ---- cell chain --------------------------------------------------------
    // cell 0 holds the nearest entry; inserts push toward the top,
    // draining pulls toward cell 0
    for (genvar g = 0; g < MAX_WANTED; g++) begin : g_cell
        logic            prev_less;
        logic [DB-1:0]   prev_dist, next_dist;
        logic [INDEX_BITS-1:0] prev_index, next_index;

        if (g == 0) begin : g_first
            assign prev_less  = 1'b1;
            assign prev_dist  = w_dist[g];
            assign prev_index = w_index[g];
        end else begin : g_mid
            assign prev_less  = w_less[g-1];
            assign prev_dist  = w_dist[g-1];
            assign prev_index = w_index[g-1];
        end

        if (g == MAX_WANTED - 1) begin : g_last
            assign next_dist  = w_dist[g];
            assign next_index = w_index[g];
        end else begin : g_inner
            assign next_dist  = w_dist[g+1];
            assign next_index = w_index[g+1];
        end

        knc_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_valid      (FW'(g) < fill_eff),
            .i_prev_less  (prev_less),
            .i_prev_dist  (prev_dist),
            .i_prev_index (prev_index),
            .i_next_dist  (next_dist),
            .i_next_index (next_index),
            .i_new_dist   (cand_dist),
            .i_new_index  (r_cand_index),
            .o_less       (w_less[g]),
            .o_dist       (w_dist[g]),
            .o_index      (w_index[g])
        );
    end

    // ---- next state --------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            knc_pkg::S_IDLE: begin
                if (s_xfer) begin
                    n_state = knc_pkg::S_CALC;
                end
            end
            knc_pkg::S_CALC: begin
                if (dist_valid) begin
                    n_state = knc_pkg::S_HINT;
                end
            end
            knc_pkg::S_HINT: begin
                if (m_xfer) begin
                    n_state = (r_fin && (r_fill != '0)) ? knc_pkg::S_DRAIN
                                                        : knc_pkg::S_IDLE;
                end
            end
            knc_pkg::S_DRAIN: begin
                if (m_xfer && (r_fill == FW'(1))) begin
                    n_state = knc_pkg::S_IDLE;
                end
            end
            default: n_state = knc_pkg::S_IDLE;
        endcase
    end

    // fill count, hint and its tlast
    always_comb begin
        n_fill      = r_fill;
        n_hint      = r_hint;
        n_hint_last = r_hint_last;
        if ((r_state == knc_pkg::S_CALC) && dist_valid) begin
            if (do_insert) begin
                n_fill = fill_eff + FW'(1);
            end
            if (!want_nz || !take) begin
                n_hint = 1'b1;
            end else begin
                n_hint = full ? hint_full : 1'b0;
            end
            n_hint_last = !r_fin || (n_fill == '0);
        end else if ((r_state == knc_pkg::S_DRAIN) && m_xfer) begin
            n_fill = fill_m1;
        end
    end

    // ---- outputs -----------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_m_tuser  = 1'b0;
        o_m_tlast  = 1'b0;
        o_m_tdata  = '0;
        case (r_state)
            knc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            knc_pkg::S_HINT: begin
                o_m_tvalid = 1'b1;
                o_m_tlast  = r_hint_last;
                o_m_tdata  = M_BITS'(r_hint);
            end
            knc_pkg::S_DRAIN: begin
                o_m_tvalid = 1'b1;
                o_m_tuser  = 1'b1;
                o_m_tlast  = (r_fill == FW'(1));
                o_m_tdata  = M_BITS'({w_dist[0], w_index[0], 1'b0});
            end
            default: ;
        endcase
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knc_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_cand_index <= i_s_tdata[3*COORD_BITS +: INDEX_BITS];
            r_fin        <= i_s_tlast;
        end
        r_hint      <= n_hint;
        r_hint_last <= n_hint_last;
    end

endmodule

`default_nettype wire

// ----- test/k_nearest_candidate_list_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k_nearest_candidate_list_unit_tb: self-checking bench for the candidate list
// streams candidates against a configured target and checks every hint and
// every sorted list entry against an in-bench model of the insertion list,
// across several target and wanted-count settings and idling patterns
// ---------------------------------------------------------------------------

module k_nearest_candidate_list_unit_tb;

    localparam int MAX_WANTED = 16;
    localparam int INDEX_BITS = 16;
    localparam int COORD_BITS = 24;
    localparam int DIST_BITS = knc_pkg::DIST_BITS;
    localparam int WANT_BITS = knc_pkg::WANT_BITS;
    localparam int S_DATA_BITS = ((3*COORD_BITS+INDEX_BITS+7)/8)*8;
    localparam int M_DATA_BITS = ((1+INDEX_BITS+DIST_BITS+7)/8)*8;
    localparam int COORD_MIN = -(1 << (COORD_BITS-1));
    localparam int COORD_MAX = (1 << (COORD_BITS-1)) - 1;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [INDEX_BITS-1:0]        index;
        logic                         fin;
    } t_cand;

    typedef struct {
        logic                  kind;
        logic                  hint;
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  distance;
        logic                  last;
    } t_neighbor_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [COORD_BITS-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_DATA_BITS-1:0] i_s_tdata = '0;
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tlast;

    k_nearest_candidate_list_unit #(
        .MAX_WANTED(MAX_WANTED),
        .INDEX_BITS(INDEX_BITS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // bench copy of the configuration and of the sorted list
    logic signed [COORD_BITS-1:0] tgt_x = '0;
    logic signed [COORD_BITS-1:0] tgt_y = '0;
    logic signed [COORD_BITS-1:0] tgt_z = '0;
    logic [WANT_BITS-1:0]         wanted = knc_pkg::WANT_RESET;
    logic [DIST_BITS-1:0]         near_dist [MAX_WANTED];
    logic [INDEX_BITS-1:0]        near_index [MAX_WANTED];
    int                           near_fill = 0;

    t_cand            cands_to_send [$];
    t_neighbor_result results_due [$];
    t_cand            offered_cand;
    logic             cand_taken = 1'b0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               fail_count = 0;

    // squared distance of a candidate to the current target, saturated
    function automatic logic [DIST_BITS-1:0] sq_distance(input t_cand c);
        longint dx, dy, dz;
        logic [63:0] s;
        dx = longint'(c.x) - longint'(tgt_x);
        dy = longint'(c.y) - longint'(tgt_y);
        dz = longint'(c.z) - longint'(tgt_z);
        s = dx*dx + dy*dy + dz*dz;
        return (s > 64'(knc_pkg::DIST_MAX)) ? knc_pkg::DIST_MAX : s[DIST_BITS-1:0];
    endfunction

    // insert one candidate into the bench list and queue the results it causes
    task automatic update_nearest_list(input t_cand c);
        int want, pos;
        logic [DIST_BITS-1:0] d;
        logic hint, full;
        t_neighbor_result r;
        want = (wanted > MAX_WANTED) ? MAX_WANTED : int'(wanted);
        d = sq_distance(c);
        hint = 1'b1;
        if (want > 0) begin
            full = (near_fill >= want);
            if (!full || d < near_dist[near_fill-1]) begin
                hint = 1'b0;
                if (full) begin
                    // last entry drops out before the new one goes in
                    near_fill--;
                    hint = (near_fill == 0) || (d > near_dist[near_fill-1]);
                end
                pos = 0;
                while (pos < near_fill && near_dist[pos] < d)
                    pos++;
                for (int i = near_fill; i > pos; i--) begin
                    near_dist[i] = near_dist[i-1];
                    near_index[i] = near_index[i-1];
                end
                near_dist[pos] = d;
                near_index[pos] = c.index;
                near_fill++;
            end
        end
        r = '{kind: 1'b0, hint: hint, index: '0, distance: '0,
              last: (!c.fin || near_fill == 0)};
        results_due.insert(results_due.size(), r);
        if (c.fin) begin
            // sorted list follows the hint, nearest first
            for (int i = 0; i < near_fill; i++) begin
                r = '{kind: 1'b1, hint: 1'b0, index: near_index[i],
                      distance: near_dist[i], last: (i + 1 == near_fill)};
                results_due.insert(results_due.size(), r);
            end
            near_fill = 0;
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver: candidate stream and result-side ready, changed on the falling edge
    always @(negedge i_clk) begin : drive_streams
        t_cand c;
        if (!i_s_tvalid || cand_taken) begin
            if (cands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                c = cands_to_send.pop_front();
                offered_cand <= c;
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {c.index, c.z, c.y, c.x};
                i_s_tlast <= c.fin;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: candidate transfers feed the model, result transfers get checked
    always @(posedge i_clk) begin : watch_streams
        t_neighbor_result want_r;
        cand_taken <= i_s_tvalid && o_s_tready;
        if (i_s_tvalid && o_s_tready)
            update_nearest_list(offered_cand);
        if (o_m_tvalid && i_m_tready) begin
            if (results_due.size() == 0) begin
                $error("result transfer with nothing expected: tdata %0h", o_m_tdata);
                fail_count++;
            end else begin
                want_r = results_due.pop_front();
                compare_field("kind", 64'(want_r.kind), 64'(o_m_tuser));
                compare_field("prune_hint", 64'(want_r.hint), 64'(o_m_tdata[0]));
                compare_field("neighbor_index", 64'(want_r.index),
                              64'(o_m_tdata[INDEX_BITS:1]));
                compare_field("neighbor_distance", 64'(want_r.distance),
                              64'(o_m_tdata[INDEX_BITS+DIST_BITS:INDEX_BITS+1]));
                compare_field("last_of_run", 64'(want_r.last), 64'(o_m_tlast));
            end
        end
    end

    task automatic write_reg(input knc_pkg::t_cfg_reg r, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= value[COORD_BITS-1:0];
        case (r)
            knc_pkg::CFG_TARGET_X: tgt_x = value[COORD_BITS-1:0];
            knc_pkg::CFG_TARGET_Y: tgt_y = value[COORD_BITS-1:0];
            knc_pkg::CFG_TARGET_Z: tgt_z = value[COORD_BITS-1:0];
            knc_pkg::CFG_WANTED:   wanted = value[WANT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_cand(input int x, input int y, input int z, input int index,
                              input bit fin);
        t_cand c;
        c.x = x[COORD_BITS-1:0];
        c.y = y[COORD_BITS-1:0];
        c.z = z[COORD_BITS-1:0];
        c.index = index[INDEX_BITS-1:0];
        c.fin = fin;
        cands_to_send.insert(cands_to_send.size(), c);
    endtask

    // every candidate offered, accepted and answered
    task automatic wait_drained();
        while (cands_to_send.size() != 0 || i_s_tvalid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // coordinate within spread of a target value, clamped to the field range
    function automatic int near_coord(input logic signed [COORD_BITS-1:0] t,
                                      input int spread);
        int v;
        v = int'(t) + int'($urandom_range(2*spread)) - spread;
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    initial begin : stimulus
        int mode, spread, w;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ties, rejects on a full list, coordinate extremes
        write_reg(knc_pkg::CFG_TARGET_X, 0);
        write_reg(knc_pkg::CFG_TARGET_Y, 0);
        write_reg(knc_pkg::CFG_TARGET_Z, 0);
        write_reg(knc_pkg::CFG_WANTED, 4);
        queue_cand(100, 0, 0, 1, 0);
        queue_cand(0, 100, 0, 2, 0);       // equal distance goes in front
        queue_cand(0, 0, -100, 3, 0);
        queue_cand(50, 50, 50, 4, 0);      // list now full
        queue_cand(0, -100, 0, 5, 0);      // equal to last entry: rejected
        queue_cand(10, 0, 0, 6, 0);        // nearer: last entry dropped
        queue_cand(COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF, 0);
        queue_cand(COORD_MAX, COORD_MAX, COORD_MAX, 0, 1);
        queue_cand(COORD_MIN, COORD_MAX, -1, 7, 1);   // one-entry list
        wait_drained();

        // nothing kept: final candidate carries tlast on its hint
        write_reg(knc_pkg::CFG_WANTED, 0);
        queue_cand(1, 2, 3, 8, 0);
        queue_cand(4, 5, 6, 9, 1);
        wait_drained();

        // extreme target, single-entry list
        write_reg(knc_pkg::CFG_TARGET_X, COORD_MIN);
        write_reg(knc_pkg::CFG_TARGET_Y, COORD_MAX);
        write_reg(knc_pkg::CFG_TARGET_Z, COORD_MIN);
        write_reg(knc_pkg::CFG_WANTED, 1);
        queue_cand(COORD_MAX, COORD_MIN, COORD_MAX, 10, 0);  // largest distance
        queue_cand(COORD_MIN, COORD_MAX, COORD_MIN, 11, 0);  // replaces it; prune hint set
        queue_cand(COORD_MIN, COORD_MAX, COORD_MIN, 12, 0);  // equal: rejected
        queue_cand(COORD_MIN + 1, COORD_MAX, COORD_MIN, 13, 1);
        wait_drained();

        // wanted count lowered and then oversized in the middle of a query
        write_reg(knc_pkg::CFG_WANTED, 4);
        queue_cand(COORD_MIN + 3, COORD_MAX, COORD_MIN, 14, 0);
        queue_cand(COORD_MIN + 1, COORD_MAX, COORD_MIN, 15, 0);
        queue_cand(COORD_MIN + 2, COORD_MAX, COORD_MIN, 16, 0);
        wait_drained();
        write_reg(knc_pkg::CFG_WANTED, 2);
        queue_cand(COORD_MIN, COORD_MAX, COORD_MIN, 17, 0);
        queue_cand(COORD_MIN + 5, COORD_MAX, COORD_MIN, 18, 0);
        wait_drained();
        write_reg(knc_pkg::CFG_WANTED, 31);
        queue_cand(COORD_MIN, COORD_MAX - 1, COORD_MIN + 1, 19, 1);
        wait_drained();

        // random queries, idling pattern cycling through the phases
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if ($urandom_range(3) == 0) begin
                write_reg(knc_pkg::CFG_TARGET_X, $urandom_range(1) ? COORD_MAX : COORD_MIN);
                write_reg(knc_pkg::CFG_TARGET_Y, $urandom_range(1) ? COORD_MAX : COORD_MIN);
            end else begin
                write_reg(knc_pkg::CFG_TARGET_X, int'($urandom()));
                write_reg(knc_pkg::CFG_TARGET_Y, int'($urandom()));
            end
            write_reg(knc_pkg::CFG_TARGET_Z, int'($urandom()));
            case ($urandom_range(7))
                0: w = 0;
                1: w = 1;
                2: w = MAX_WANTED;
                3: w = $urandom_range(31, MAX_WANTED + 1);
                default: w = $urandom_range(MAX_WANTED - 1, 2);
            endcase
            if (p == 0) w = MAX_WANTED;
            write_reg(knc_pkg::CFG_WANTED, w);
            for (int n = 0; n < 38; n++) begin
                mode = $urandom_range(99);
                // tight spread makes equal distances common
                spread = (mode < 70) ? 6 : 4096;
                if (mode < 85)
                    queue_cand(near_coord(tgt_x, spread), near_coord(tgt_y, spread),
                               near_coord(tgt_z, spread), $urandom_range(65535),
                               (n == 37) || ($urandom_range(6) == 0));
                else
                    queue_cand(int'($urandom()), int'($urandom()), int'($urandom()),
                               $urandom_range(65535),
                               (n == 37) || ($urandom_range(6) == 0));
            end
            wait_drained();
        end

        // allow for anything stray still in the pipeline
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : run_limit
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- k_nearest_candidate_list_unit.f -----
rtl/knc_pkg.sv
rtl/knc_dist.sv
rtl/knc_cell.sv
rtl/k_nearest_candidate_list_unit.sv
test/k_nearest_candidate_list_unit_tb.sv
